@@ src/ppu_reg_pkg.sv @@
// ----------------------------------------------------------------------------
// ppu_reg_pkg
// shared types and constants for the video processor cpu register port
// ----------------------------------------------------------------------------
package ppu_reg_pkg;

    localparam int ADDR_W = 15;

    localparam logic [ADDR_W-1:0] PALETTE_BASE = 15'h3F00;
    localparam logic [ADDR_W-1:0] STEP_ACROSS  = 15'd1;
    localparam logic [ADDR_W-1:0] STEP_DOWN    = 15'd32;

    typedef enum logic [1:0] {
        OP_READ      = 2'd0,
        OP_WRITE     = 2'd1,
        OP_VBL_START = 2'd2,
        OP_VBL_END   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_CTRL    = 3'd0,
        REG_MASK    = 3'd1,
        REG_STATUS  = 3'd2,
        REG_OAMADDR = 3'd3,
        REG_OAMDATA = 3'd4,
        REG_SCROLL  = 3'd5,
        REG_ADDR    = 3'd6,
        REG_DATA    = 3'd7
    } reg_sel_t;

    // result of one transfer, before the sprite memory read data is merged in
    typedef struct packed {
        logic [7:0]        rdata;
        logic [ADDR_W-1:0] vram_addr;
        logic              vram_read;
        logic              vram_write;
        logic              nmi_pulse;
        logic [2:0]        fine_x;
        logic [7:0]        mask;
        logic              oam_read;
    } result_t;

    // sprite memory access request
    typedef struct packed {
        logic       we;
        logic       re;
        logic [7:0] wdata;
    } oam_req_t;

endpackage

@@ src/ppu_reg_oam.sv @@
// ----------------------------------------------------------------------------
// ppu_reg_oam
// sprite memory: one write port, one registered read port
// ----------------------------------------------------------------------------
module ppu_reg_oam #(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8
) (
    input  logic             aclk,
    input  logic             we,
    input  logic             re,
    input  logic [IDX_W-1:0] addr,
    input  logic [7:0]       wdata,
    output logic [7:0]       rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/ppu_reg_core.sv @@
// ----------------------------------------------------------------------------
// ppu_reg_core
// register file state and per-transfer decode of the cpu register port
// ----------------------------------------------------------------------------
module ppu_reg_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  ppu_reg_pkg::op_t      op,
    input  ppu_reg_pkg::reg_sel_t reg_sel,
    input  logic [7:0]            wdata,
    input  logic [7:0]            vram_rdata,
    output ppu_reg_pkg::result_t  res,
    output ppu_reg_pkg::oam_req_t oam_req,
    output logic [7:0]            oam_addr
);

    import ppu_reg_pkg::*;

    logic [7:0]        ctrl_reg,  ctrl_next;
    logic [7:0]        mask_reg,  mask_next;
    logic [ADDR_W-1:0] v_reg,     v_next;
    logic [ADDR_W-1:0] t_reg,     t_next;
    logic [2:0]        fx_reg,    fx_next;
    logic              w_reg,     w_next;
    logic [7:0]        buf_reg,   buf_next;
    logic              vbl_reg,   vbl_next;
    logic [7:0]        oaddr_reg, oaddr_next;

    logic [ADDR_W-1:0] v_inc;

    assign v_inc = v_reg + (ctrl_reg[2] ? STEP_DOWN : STEP_ACROSS);

    always_comb begin
        ctrl_next  = ctrl_reg;
        mask_next  = mask_reg;
        v_next     = v_reg;
        t_next     = t_reg;
        fx_next    = fx_reg;
        w_next     = w_reg;
        buf_next   = buf_reg;
        vbl_next   = vbl_reg;
        oaddr_next = oaddr_reg;

        res         = '0;
        oam_req     = '0;
        oam_req.wdata = wdata;

        case (op)
            OP_READ: begin
                case (reg_sel)
                    REG_STATUS: begin
                        res.rdata = {vbl_reg, 2'b00, buf_reg[4:0]};
                        vbl_next  = 1'b0;
                        w_next    = 1'b0;
                    end
                    REG_OAMDATA: begin
                        res.oam_read = 1'b1;
                        oam_req.re   = 1'b1;
                    end
                    REG_DATA: begin
                        res.vram_addr = v_reg;
                        res.vram_read = 1'b1;
                        if (v_reg >= PALETTE_BASE) begin
                            res.rdata = vram_rdata;
                        end else begin
                            res.rdata = buf_reg;
                            buf_next  = vram_rdata;
                        end
                        v_next = v_inc;
                    end
                    default: begin
                    end
                endcase
            end
            OP_WRITE: begin
                case (reg_sel)
                    REG_CTRL: begin
                        ctrl_next = wdata;
                        t_next    = {t_reg[14:12], wdata[1:0], t_reg[9:0]};
                    end
                    REG_MASK: begin
                        mask_next = wdata;
                    end
                    REG_OAMADDR: begin
                        oaddr_next = wdata;
                    end
                    REG_OAMDATA: begin
                        oam_req.we = 1'b1;
                    end
                    REG_SCROLL: begin
                        if (!w_reg) begin
                            t_next  = {t_reg[14:5], wdata[7:3]};
                            fx_next = wdata[2:0];
                        end else begin
                            t_next = {wdata[2:0], t_reg[11:10], wdata[7:3], t_reg[4:0]};
                        end
                        w_next = ~w_reg;
                    end
                    REG_ADDR: begin
                        if (!w_reg) begin
                            t_next = {1'b0, wdata[5:0], t_reg[7:0]};
                        end else begin
                            t_next = {t_reg[14:8], wdata};
                            v_next = {t_reg[14:8], wdata};
                        end
                        w_next = ~w_reg;
                    end
                    REG_DATA: begin
                        res.vram_addr  = v_reg;
                        res.vram_write = 1'b1;
                        v_next         = v_inc;
                    end
                    default: begin
                    end
                endcase
            end
            OP_VBL_START: begin
                vbl_next      = 1'b1;
                res.nmi_pulse = ctrl_reg[7];
            end
            default: begin
                vbl_next = 1'b0;
            end
        endcase

        res.fine_x = fx_next;
        res.mask   = mask_next;
    end

    assign oam_addr = oaddr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg  <= '0;
            mask_reg  <= '0;
            v_reg     <= '0;
            t_reg     <= '0;
            fx_reg    <= '0;
            w_reg     <= 1'b0;
            buf_reg   <= '0;
            vbl_reg   <= 1'b0;
            oaddr_reg <= '0;
        end else if (step_en) begin
            ctrl_reg  <= ctrl_next;
            mask_reg  <= mask_next;
            v_reg     <= v_next;
            t_reg     <= t_next;
            fx_reg    <= fx_next;
            w_reg     <= w_next;
            buf_reg   <= buf_next;
            vbl_reg   <= vbl_next;
            oaddr_reg <= oaddr_next;
        end
    end

endmodule

@@ src/ppu_cpu_register_port.sv @@
// a result passes the input register, then the result register, before it is offered
//   on m_; a stall on m_ can hold it in either
// throughput: one transfer per cycle unless m_ stalls; one register file pass per item
// reset: aresetn synchronous active low clears the pipeline valids and all register file
//   state; sprite memory contents are left as they were
// ----------------------------------------------------------------------------
// ppu_cpu_register_port
// cpu-side register port of a tile video processor: control, mask, status,
// sprite memory, scroll, address and data registers plus vblank events
// ----------------------------------------------------------------------------
module ppu_cpu_register_port #(
    parameter int SPRITE_MEM_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] wdata, [15:8] vram_rdata
    input  logic [4:0]  s_tuser,   // [1:0] op, [4:2] reg_sel

    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] rdata, [22:8] vram_addr, [25:23] fine_x_out,
                                   // [33:26] render_mask, [39:34] zero
    output logic [2:0]  m_tuser    // [0] vram_read, [1] vram_write, [2] nmi_pulse
);

    import ppu_reg_pkg::*;

    localparam int IDX_W = $clog2(SPRITE_MEM_DEPTH);

    // input register
    logic       in_valid_reg, in_valid_next;
    op_t        op_reg;
    reg_sel_t   sel_reg;
    logic [7:0] wdata_reg;
    logic [7:0] vdata_reg;

    // result register
    logic       out_valid_reg, out_valid_next;
    result_t    res_reg;

    // handshake control
    logic       s_xfer;
    logic       out_adv;   // result register can take a new item
    logic       step_en;   // item moves from input register to result register

    result_t    res;
    oam_req_t   oam_req;
    logic [7:0] oam_addr;
    logic [7:0] oam_rdata;

    assign out_adv  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_adv;
    assign s_tready = !in_valid_reg || out_adv;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (step_en) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (step_en) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg    <= op_t'(s_tuser[1:0]);
            sel_reg   <= reg_sel_t'(s_tuser[4:2]);
            wdata_reg <= s_tdata[7:0];
            vdata_reg <= s_tdata[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            res_reg <= res;
        end
    end

    // register file and decode
    ppu_reg_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .op         (op_reg),
        .reg_sel    (sel_reg),
        .wdata      (wdata_reg),
        .vram_rdata (vdata_reg),
        .res        (res),
        .oam_req    (oam_req),
        .oam_addr   (oam_addr)
    );

    // sprite memory, read data lands alongside the result register
    ppu_reg_oam #(
        .DEPTH (SPRITE_MEM_DEPTH),
        .IDX_W (IDX_W)
    ) u_oam (
        .aclk  (aclk),
        .we    (step_en && oam_req.we),
        .re    (step_en && oam_req.re),
        .addr  (oam_addr[IDX_W-1:0]),
        .wdata (oam_req.wdata),
        .rdata (oam_rdata)
    );

    // sprite reads take the memory output, everything else the registered byte
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, res_reg.mask, res_reg.fine_x, res_reg.vram_addr,
                       (res_reg.oam_read ? oam_rdata : res_reg.rdata)};
    assign m_tuser  = {res_reg.nmi_pulse, res_reg.vram_write, res_reg.vram_read};

    // a vram access is either a read or a write, never both
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("vram read and write flagged together");

    // an interrupt pulse comes from a vblank event, which touches no register data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> (m_tdata[7:0] == 8'h00 && m_tuser[1:0] == 2'b00))
        else $error("nmi pulse alongside register traffic");

    // no vram access means no address is reported
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == 2'b00) |-> (m_tdata[22:8] == '0))
        else $error("vram address without vram access");

    // a held item stays in the input register until it is processed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !step_en) |=> in_valid_reg)
        else $error("input item lost");

    // each processed item produces a result on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> m_tvalid)
        else $error("processed item without result");

endmodule

@@ tb/ppu_port_scoreboard_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppu_port_scoreboard_pkg
// register file predictor and in-order result checker for the cpu register
// port testbench
// ----------------------------------------------------------------------------
package ppu_port_scoreboard_pkg;

    import ppu_reg_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0]        rdata;
        logic [ADDR_W-1:0] vram_addr;
        logic              vram_read;
        logic              vram_write;
        logic              nmi_pulse;
        logic [2:0]        fine_x;
        logic [7:0]        mask;
    } port_result_t;

    class port_scoreboard;

        // shadow of the register file
        logic [7:0]        ctrl_r;
        logic [7:0]        mask_r;
        logic [7:0]        rbuf_r;
        logic [7:0]        oam_ptr_r;
        logic [ADDR_W-1:0] v_r;
        logic [ADDR_W-1:0] t_r;
        logic [2:0]        fine_x_r;
        logic              toggle_r;
        logic              vblank_r;
        logic [7:0]        oam_r [256];

        port_result_t      pending_results [$];

        int unsigned errors    = 0;
        int unsigned checked   = 0;
        int unsigned n_reads   = 0;
        int unsigned n_writes  = 0;
        int unsigned n_vbl     = 0;
        int unsigned n_palette = 0;
        int unsigned n_wraps   = 0;
        int unsigned n_nmi     = 0;

        function new();
            ctrl_r    = '0;
            mask_r    = '0;
            rbuf_r    = '0;
            oam_ptr_r = '0;
            v_r       = '0;
            t_r       = '0;
            fine_x_r  = '0;
            toggle_r  = 1'b0;
            vblank_r  = 1'b0;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function string describe(port_result_t r);
            return $sformatf("rdata %02h addr %04h rd %0b wr %0b nmi %0b fine_x %0d mask %02h",
                             r.rdata, r.vram_addr, r.vram_read, r.vram_write, r.nmi_pulse,
                             r.fine_x, r.mask);
        endfunction

        // data port step: 1 across or 32 down, wrapping at 15 bits
        function void step_address();
            logic [ADDR_W-1:0] next_v;
            next_v = v_r + (ctrl_r[2] ? STEP_DOWN : STEP_ACROSS);
            if (next_v < v_r) n_wraps++;
            v_r = next_v;
        endfunction

        function void note_transfer(op_t op, reg_sel_t sel, logic [7:0] wd, logic [7:0] vd);
            port_result_t res;
            res = '0;
            case (op)
                OP_READ: begin
                    n_reads++;
                    case (sel)
                        REG_STATUS: begin
                            res.rdata = {vblank_r, 2'b00, rbuf_r[4:0]};
                            vblank_r  = 1'b0;
                            toggle_r  = 1'b0;
                        end
                        REG_OAMDATA: res.rdata = oam_r[oam_ptr_r];
                        REG_DATA: begin
                            res.vram_addr = v_r;
                            res.vram_read = 1'b1;
                            if (v_r >= PALETTE_BASE) begin
                                res.rdata = vd;
                                n_palette++;
                            end else begin
                                res.rdata = rbuf_r;
                                rbuf_r    = vd;
                            end
                            step_address();
                        end
                        default: ;
                    endcase
                end
                OP_WRITE: begin
                    n_writes++;
                    case (sel)
                        REG_CTRL: begin
                            ctrl_r      = wd;
                            t_r[11:10]  = wd[1:0];
                        end
                        REG_MASK:    mask_r    = wd;
                        REG_OAMADDR: oam_ptr_r = wd;
                        REG_OAMDATA: oam_r[oam_ptr_r] = wd;
                        REG_SCROLL: begin
                            if (!toggle_r) begin
                                t_r[4:0] = wd[7:3];
                                fine_x_r = wd[2:0];
                            end else begin
                                t_r[9:5]   = wd[7:3];
                                t_r[14:12] = wd[2:0];
                            end
                            toggle_r = ~toggle_r;
                        end
                        REG_ADDR: begin
                            if (!toggle_r) begin
                                t_r[13:8] = wd[5:0];
                                t_r[14]   = 1'b0;
                            end else begin
                                t_r[7:0] = wd;
                                v_r      = t_r;
                            end
                            toggle_r = ~toggle_r;
                        end
                        REG_DATA: begin
                            res.vram_addr  = v_r;
                            res.vram_write = 1'b1;
                            step_address();
                        end
                        default: ;
                    endcase
                end
                OP_VBL_START: begin
                    n_vbl++;
                    vblank_r      = 1'b1;
                    res.nmi_pulse = ctrl_r[7];
                    if (ctrl_r[7]) n_nmi++;
                end
                default: begin
                    n_vbl++;
                    vblank_r = 1'b0;
                end
            endcase
            res.fine_x = fine_x_r;
            res.mask   = mask_r;
            pending_results.push_back(res);
        endfunction

        function void check_result(port_result_t got);
            port_result_t want;
            checked++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("result transfer with nothing outstanding: %s", describe(got));
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_LIMIT) begin
                    $display("mismatch on result %0d", checked);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
            end
        endfunction

        function void close_out();
            if (pending_results.size() != 0) begin
                errors += pending_results.size();
                $display("%0d expected results never arrived", pending_results.size());
            end
        endfunction

    endclass

endpackage

@@ tb/ppu_cpu_register_port_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppu_cpu_register_port_tb
// drives register reads, writes and vblank events into the cpu register port
// with bursty input and a stalling receiver, predicts every result from a
// shadow register file and checks each result transfer in order
// ----------------------------------------------------------------------------
module ppu_cpu_register_port_tb;

    import ppu_reg_pkg::*;
    import ppu_port_scoreboard_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1900;

    // receiver stall styles, changed at random each time rx_phase wraps
    typedef enum int {
        RX_STREAM,
        RX_RANDOM,
        RX_PERIODIC,
        RX_STARVED
    } rx_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [7:0] wdata, [15:8] vram_rdata
    logic [4:0]  s_tuser  = '0;    // [1:0] op, [4:2] reg_sel
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [7:0] rdata, [22:8] vram_addr, [25:23] fine_x_out,
                                   // [33:26] render_mask, [39:34] zero
    logic [2:0]  m_tuser;          // [0] vram_read, [1] vram_write, [2] nmi_pulse

    port_scoreboard sb = new();
    port_result_t   seen;

    // sender state: burst bookkeeping and a view of sprite memory so that
    // no sprite read ever lands on an entry that was never written
    int unsigned burst_left = 0;
    int unsigned stim_count = 0;
    logic [7:0]  gen_oam_ptr = '0;
    bit          gen_oam_written [256];

    rx_mode_t    rx_mode  = RX_STREAM;
    logic [7:0]  rx_phase = '0;

    ppu_cpu_register_port dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // safety net well beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("run timed out with %0d results outstanding", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: back-pressure on a pattern of its own, including full-rate stretches
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 8'd1;
        if (rx_phase == 8'd255)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_STREAM:   m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_tready <= ((rx_phase % 5) < 3);
            default:     m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // monitor: both channels sampled at the edge where the transfer happens
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_transfer(op_t'(s_tuser[1:0]), reg_sel_t'(s_tuser[4:2]),
                             s_tdata[7:0], s_tdata[15:8]);
        if (aresetn && m_tvalid && m_tready) begin
            seen.rdata      = m_tdata[7:0];
            seen.vram_addr  = m_tdata[22:8];
            seen.fine_x     = m_tdata[25:23];
            seen.mask       = m_tdata[33:26];
            seen.vram_read  = m_tuser[0];
            seen.vram_write = m_tuser[1];
            seen.nmi_pulse  = m_tuser[2];
            sb.check_result(seen);
        end
    end

    function automatic logic [7:0] rand8();
        return 8'($urandom);
    endfunction

    // one input transfer; the sender works in bursts with random gaps between them
    task automatic send(input op_t op, input reg_sel_t sel, input logic [7:0] wd,
                        input logic [7:0] vd);
        int unsigned gap;
        // a sprite read of a never-written entry becomes a write of that entry
        if (op == OP_READ && sel == REG_OAMDATA && !gen_oam_written[gen_oam_ptr])
            op = OP_WRITE;
        if (op == OP_WRITE && sel == REG_OAMADDR) gen_oam_ptr = wd;
        if (op == OP_WRITE && sel == REG_OAMDATA) gen_oam_written[gen_oam_ptr] = 1'b1;
        // status writes are ignored by the register file, so they do not count as stimulus
        if (!(op == OP_WRITE && sel == REG_STATUS)) stim_count++;

        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {sel, op};
        s_tdata  <= {vd, wd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // hold the sender off until every outstanding result has been checked
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic run_directed();
        // unserved registers read back as zero
        send(OP_READ,  REG_CTRL,    8'h00, 8'hFF);
        send(OP_READ,  REG_MASK,    8'hFF, 8'h00);
        send(OP_READ,  REG_OAMADDR, 8'h00, 8'hFF);
        send(OP_READ,  REG_SCROLL,  8'hFF, 8'h00);
        send(OP_READ,  REG_ADDR,    8'h00, 8'hFF);
        // status write is ignored
        send(OP_WRITE, REG_STATUS,  8'hFF, 8'h00);
        send(OP_WRITE, REG_MASK,    8'hFF, 8'h00);
        // interrupt enabled, step across
        send(OP_WRITE, REG_CTRL,    8'h80, 8'h00);
        send(OP_VBL_START, REG_CTRL, 8'h00, 8'h00);
        send(OP_READ,  REG_STATUS,  8'h00, 8'h00);
        // sprite data at the top entry, no auto increment
        send(OP_WRITE, REG_OAMADDR, 8'hFF, 8'h00);
        send(OP_WRITE, REG_OAMDATA, 8'hA5, 8'h00);
        send(OP_READ,  REG_OAMDATA, 8'h00, 8'h00);
        // high address write with the top bits set, then a palette-range read
        send(OP_WRITE, REG_ADDR,    8'hFF, 8'h00);
        send(OP_WRITE, REG_ADDR,    8'h00, 8'h00);
        send(OP_READ,  REG_DATA,    8'h00, 8'hC3);
        // build v = 7fff through the scroll path, then wrap on a data write
        send(OP_WRITE, REG_ADDR,    8'h3F, 8'h00);
        send(OP_WRITE, REG_SCROLL,  8'hFF, 8'h00);
        send(OP_WRITE, REG_SCROLL,  8'h00, 8'h00);
        send(OP_WRITE, REG_ADDR,    8'hFF, 8'h00);
        send(OP_WRITE, REG_DATA,    8'h5A, 8'h00);
        // buffered read below the palette range
        send(OP_READ,  REG_DATA,    8'h00, 8'h00);
        // step down, interrupt off
        send(OP_WRITE, REG_CTRL,    8'h7F, 8'h00);
        send(OP_READ,  REG_DATA,    8'h00, 8'hFF);
        send(OP_VBL_START, REG_DATA, 8'hFF, 8'hFF);
        send(OP_VBL_END,   REG_DATA, 8'hFF, 8'hFF);
    endtask

    // mostly well-formed access sequences with random contents, some noise
    task automatic run_random();
        int unsigned start_count;
        int unsigned n;
        bit          mid_drained;
        logic [7:0]  hi;
        start_count = stim_count;
        mid_drained = 1'b0;
        while (stim_count - start_count < RANDOM_ITEMS) begin
            if (!mid_drained && stim_count - start_count >= RANDOM_ITEMS / 2) begin
                drain_results();
                mid_drained = 1'b1;
            end
            case ($urandom_range(0, 9))
                0, 1: begin
                    // address pair, often aimed at the palette range, then data accesses
                    if ($urandom_range(0, 3) != 0) send(OP_READ, REG_STATUS, rand8(), rand8());
                    hi = ($urandom_range(0, 2) == 0) ? {2'($urandom), 6'h3F} : rand8();
                    send(OP_WRITE, REG_ADDR, hi, rand8());
                    send(OP_WRITE, REG_ADDR, rand8(), rand8());
                    n = $urandom_range(1, 6);
                    repeat (n)
                        send($urandom_range(0, 1) ? OP_READ : OP_WRITE, REG_DATA,
                             rand8(), rand8());
                end
                2: begin
                    if ($urandom_range(0, 1)) send(OP_READ, REG_STATUS, rand8(), rand8());
                    send(OP_WRITE, REG_SCROLL, rand8(), rand8());
                    send(OP_WRITE, REG_SCROLL, rand8(), rand8());
                end
                3: send(OP_WRITE, REG_CTRL, rand8(), rand8());
                4: send(OP_WRITE, REG_MASK, rand8(), rand8());
                5: begin
                    send(OP_WRITE, REG_OAMADDR, rand8(), rand8());
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send($urandom_range(0, 1) ? OP_READ : OP_WRITE, REG_OAMDATA,
                             rand8(), rand8());
                end
                6: begin
                    send(OP_VBL_START, reg_sel_t'($urandom_range(0, 7)), rand8(), rand8());
                    n = $urandom_range(0, 3);
                    repeat (n) send(OP_READ, REG_STATUS, rand8(), rand8());
                    send(OP_VBL_END, reg_sel_t'($urandom_range(0, 7)), rand8(), rand8());
                end
                7: begin
                    n = $urandom_range(1, 8);
                    repeat (n)
                        send($urandom_range(0, 1) ? OP_READ : OP_WRITE, REG_DATA,
                             rand8(), rand8());
                end
                default: begin
                    // noise: any operation on any register
                    send(op_t'($urandom_range(0, 3)), reg_sel_t'($urandom_range(0, 7)),
                         rand8(), rand8());
                end
            endcase
        end
    endtask

    initial begin
        // synchronous reset applied once, at the start
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        drain_results();
        run_random();

        // let the pipeline settle so that stray results are caught
        drain_results();
        repeat (8) @(posedge aclk);
        sb.close_out();

        $display("covered %0d transfers: %0d reads, %0d writes, %0d vblank events",
                 sb.n_reads + sb.n_writes + sb.n_vbl, sb.n_reads, sb.n_writes, sb.n_vbl);
        $display("  %0d palette-range reads, %0d address wraps, %0d nmi pulses, %0d results",
                 sb.n_palette, sb.n_wraps, sb.n_nmi, sb.checked);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures", sb.errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
